// ===== rtl/core/etpc_pkg.sv =====
// Shared types and constants of the ESC throttle pulse controller.
package etpc_pkg;

	// Input item opcodes.
	localparam logic [1:0] OP_SET_THROTTLE  = 2'd0;
	localparam logic [1:0] OP_SET_DIRECTION = 2'd1;
	localparam logic [1:0] OP_TICK          = 2'd2;

	// Configuration register map, one 32-bit word per register.
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_MODE_3D      = 3'd0,
		REG_PULSE_MIN    = 3'd1,
		REG_PULSE_CENTER = 3'd2,
		REG_PULSE_MAX    = 3'd3,
		REG_REVERSE_DEAD = 3'd4,
		REG_PWM_FREQ     = 3'd5,
		REG_PWM_BITS     = 3'd6
	} reg_idx_t;

	// Throttle percent limit and the reciprocal used for division by 100:
	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^20.
	localparam logic [6:0]  PCT_MAX     = 7'd100;
	localparam logic [19:0] RECIP_100   = 20'd671089;
	localparam int          RECIP_SHIFT = 26;

	// Duty conversion: (pulse * freq * (2^bits - 1)) / 1e6.
	// The dividend is below 2^38 and the quotient below 2^19.
	localparam int          SCALE_W   = 22;
	localparam int          DVD_W     = 38;
	localparam int          QUO_W     = 19;

	// Division by one million, with 1e6 = 64 * 15625:
	// floor(x / 1e6) == ((x >> PRESHIFT) * RECIP_1E6) >> RECIP_1E6_SHIFT
	// for every x below 2^38.
	localparam int          PRESHIFT        = 6;
	localparam int          Y_W             = DVD_W - PRESHIFT;
	localparam int          RECIP_1E6_W     = 31;
	localparam logic [30:0] RECIP_1E6       = 31'd1125899907;
	localparam int          RECIP_1E6_SHIFT = 44;
	localparam int          DPROD_W         = Y_W + RECIP_1E6_W;
	localparam logic [4:0]  PWM_BITS_MIN = 5'd1;
	localparam logic [4:0]  PWM_BITS_MAX = 5'd16;

	typedef struct packed {
		logic [1:0] opcode;
		logic [6:0] throttle_percent;
		logic       dir_request;
	} cmd_item_t;

	typedef struct packed {
		logic [15:0] duty_count;
		logic [11:0] pulse_us;
	} res_item_t;

	typedef struct packed {
		logic        mode_3d;
		logic [11:0] pulse_min_us;
		logic [11:0] pulse_center_us;
		logic [11:0] pulse_max_us;
		logic [15:0] reverse_dead_ms;
		logic [9:0]  pwm_freq_hz;
		logic [4:0]  pwm_bits;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RECIP,
		ST_PULSE,
		ST_SCALE,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} ctrl_state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic take;
		logic mul;
		logic recip;
		logic pulse;
		logic scale;
		logic div_load;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic is_tick;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/core/etpc_stream_if.sv =====
// Valid/ready stream interface that carries one item per handshake.
interface etpc_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/etpc_regs.sv =====
// APB configuration register file of the ESC throttle pulse controller.
module etpc_regs
	import etpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_3d         <= 1'b0;
			cfg_q.pulse_min_us    <= 12'd1000;
			cfg_q.pulse_center_us <= 12'd1500;
			cfg_q.pulse_max_us    <= 12'd2000;
			cfg_q.reverse_dead_ms <= 16'd0;
			cfg_q.pwm_freq_hz     <= 10'd50;
			cfg_q.pwm_bits        <= 5'd16;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE_3D:      cfg_q.mode_3d         <= pwdata[0];
				REG_PULSE_MIN:    cfg_q.pulse_min_us    <= pwdata[11:0];
				REG_PULSE_CENTER: cfg_q.pulse_center_us <= pwdata[11:0];
				REG_PULSE_MAX:    cfg_q.pulse_max_us    <= pwdata[11:0];
				REG_REVERSE_DEAD: cfg_q.reverse_dead_ms <= pwdata[15:0];
				REG_PWM_FREQ:     cfg_q.pwm_freq_hz     <= pwdata[9:0];
				REG_PWM_BITS:     cfg_q.pwm_bits        <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_MODE_3D:      prdata = PDATA_W'(cfg_q.mode_3d);
			REG_PULSE_MIN:    prdata = PDATA_W'(cfg_q.pulse_min_us);
			REG_PULSE_CENTER: prdata = PDATA_W'(cfg_q.pulse_center_us);
			REG_PULSE_MAX:    prdata = PDATA_W'(cfg_q.pulse_max_us);
			REG_REVERSE_DEAD: prdata = PDATA_W'(cfg_q.reverse_dead_ms);
			REG_PWM_FREQ:     prdata = PDATA_W'(cfg_q.pwm_freq_hz);
			REG_PWM_BITS:     prdata = PDATA_W'(cfg_q.pwm_bits);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/etpc_ctrl.sv =====
// Sequencing state machine of the ESC throttle pulse controller.
module etpc_ctrl
	import etpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t dp_sts,
	output dp_cmd_t dp_cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		dp_cmd   = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_cmd.take = 1'b1;
					if (dp_sts.is_tick) begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				dp_cmd.mul = 1'b1;
				state_d    = ST_RECIP;
			end
			ST_RECIP: begin
				dp_cmd.recip = 1'b1;
				state_d      = ST_PULSE;
			end
			ST_PULSE: begin
				dp_cmd.pulse = 1'b1;
				state_d      = ST_SCALE;
			end
			ST_SCALE: begin
				dp_cmd.scale = 1'b1;
				state_d      = ST_LOAD;
			end
			ST_LOAD: begin
				dp_cmd.div_load = 1'b1;
				state_d         = ST_DIV;
			end
			ST_DIV: begin
				dp_cmd.div_step = 1'b1;
				state_d         = ST_OUT;
			end
			ST_OUT: begin
				if (dp_sts.out_free) begin
					dp_cmd.out_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/etpc_dp.sv =====
// Datapath of the ESC throttle pulse controller: state, pulse mapping, duty divide.
module etpc_dp
	import etpc_pkg::*;
#(
	parameter int INPUT_TIMEOUT_MS = 300
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_item_t in_data,
	input  cfg_t      cfg,
	input  dp_cmd_t   dp_cmd,
	output dp_sts_t   dp_sts,
	output logic      out_valid,
	input  logic      out_ready,
	output res_item_t out_data
);

	// The idle counter saturates at one above the timeout.
	localparam int IDLE_W = $clog2(INPUT_TIMEOUT_MS + 2);
	localparam logic [IDLE_W-1:0] TIMEOUT = IDLE_W'(INPUT_TIMEOUT_MS);

	// Controller-visible state.
	logic [6:0]        throttle_q;
	logic [IDLE_W-1:0] idle_q;
	logic              dir_q;
	logic              pend_q;
	logic [15:0]       remain_q;

	// Pipeline registers.
	logic [11:0]          a_s1;
	logic [11:0]          b_s1;
	logic [6:0]           pct_s1;
	logic [11:0]          a_s2;
	logic                 neg_s2;
	logic [18:0]          prod_s2;
	logic [11:0]          a_s3;
	logic                 neg_s3;
	logic [11:0]          quo_s3;
	logic [11:0]          us_s4;
	logic [SCALE_W-1:0]   m_s5;
	logic [Y_W-1:0]       y_s6;
	logic [QUO_W-1:0]     quo_q;
	logic                 out_valid_q;
	res_item_t            out_q;

	logic [IDLE_W-1:0] idle_inc;
	logic              timeout;
	logic [15:0]       remain_dec;
	logic [6:0]        pct_sat;
	logic [12:0]       diff;
	logic [11:0]       diff_mag;
	logic [38:0]       recip_prod;
	logic [4:0]        bits_eff;
	logic [15:0]       top;
	logic [DVD_W-1:0]  m_ext;
	logic [DVD_W-1:0]  dividend;
	logic [DPROD_W-1:0] div_prod;

	// Tick bookkeeping.
	assign idle_inc   = (idle_q <= TIMEOUT) ? idle_q + 1'b1 : idle_q;
	assign timeout    = idle_inc > TIMEOUT;
	assign remain_dec = (remain_q != 16'd0) ? remain_q - 16'd1 : 16'd0;
	assign pct_sat    = (in_data.throttle_percent > PCT_MAX) ? PCT_MAX
	                                                         : in_data.throttle_percent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_q <= '0;
			idle_q     <= '0;
			dir_q      <= 1'b0;
			pend_q     <= 1'b0;
			remain_q   <= '0;
		end else if (dp_cmd.take) begin
			unique case (in_data.opcode)
				OP_SET_THROTTLE: begin
					throttle_q <= pct_sat;
					idle_q     <= '0;
				end
				OP_SET_DIRECTION: begin
					if (cfg.mode_3d && (in_data.dir_request != dir_q)) begin
						dir_q      <= in_data.dir_request;
						pend_q     <= 1'b1;
						remain_q   <= cfg.reverse_dead_ms;
						throttle_q <= '0;
					end
				end
				OP_TICK: begin
					idle_q <= idle_inc;
					if (timeout) begin
						throttle_q <= '0;
					end
					if (pend_q) begin
						remain_q <= remain_dec;
						if (remain_dec == 16'd0) begin
							pend_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Mapping end points. Neutral output is the start point with zero percent.
	always_ff @(posedge clk) begin
		if (dp_cmd.take) begin
			if (cfg.mode_3d) begin
				a_s1 <= cfg.pulse_center_us;
				b_s1 <= dir_q ? cfg.pulse_min_us : cfg.pulse_max_us;
			end else begin
				a_s1 <= cfg.pulse_min_us;
				b_s1 <= cfg.pulse_max_us;
			end
			pct_s1 <= (pend_q || timeout) ? 7'd0 : throttle_q;
		end
	end

	assign diff     = {1'b0, b_s1} - {1'b0, a_s1};
	assign diff_mag = diff[12] ? 12'(-diff) : diff[11:0];

	always_ff @(posedge clk) begin
		if (dp_cmd.mul) begin
			a_s2    <= a_s1;
			neg_s2  <= diff[12];
			prod_s2 <= 19'(pct_s1 * diff_mag);
		end
	end

	// Division by 100 of the magnitude, truncating toward zero.
	assign recip_prod = 39'(prod_s2 * RECIP_100);

	always_ff @(posedge clk) begin
		if (dp_cmd.recip) begin
			a_s3   <= a_s2;
			neg_s3 <= neg_s2;
			quo_s3 <= recip_prod[RECIP_SHIFT +: 12];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.pulse) begin
			us_s4 <= neg_s3 ? a_s3 - quo_s3 : a_s3 + quo_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.scale) begin
			m_s5 <= SCALE_W'(us_s4 * cfg.pwm_freq_hz);
		end
	end

	// Duty resolution clamp and the full-scale count 2^bits - 1.
	assign bits_eff = (cfg.pwm_bits < PWM_BITS_MIN) ? PWM_BITS_MIN :
	                  (cfg.pwm_bits > PWM_BITS_MAX) ? PWM_BITS_MAX : cfg.pwm_bits;
	assign top      = 16'((17'd1 << bits_eff) - 17'd1);
	assign m_ext    = DVD_W'(m_s5);
	assign dividend = (m_ext << bits_eff) - m_ext;

	// Divide by one million: drop the factor 64 by a shift, then take the
	// quotient by 15625 from a reciprocal multiply in the next cycle.
	assign div_prod = DPROD_W'(y_s6) * DPROD_W'(RECIP_1E6);

	always_ff @(posedge clk) begin
		if (dp_cmd.div_load) begin
			y_s6 <= dividend[DVD_W-1:PRESHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.div_step) begin
			quo_q <= div_prod[RECIP_1E6_SHIFT +: QUO_W];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			out_q.duty_count <= (quo_q > QUO_W'(top)) ? top : quo_q[15:0];
			out_q.pulse_us   <= us_s4;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign dp_sts.is_tick  = in_data.opcode == OP_TICK;
	assign dp_sts.out_free = !out_valid_q || out_ready;

endmodule

// ===== rtl/core/esc_throttle_pulse_controller_core.sv =====
// Top level of the ESC throttle pulse controller.
//
// The controller turns a stream of command items into servo-style pulse widths
// for an electronic speed controller. A set-throttle item stores a percent
// (values above 100 count as 100) and restarts the command-loss timer. A
// set-direction item matters only in 3D mode and only when it changes the
// direction; it zeroes the throttle and starts the reverse dead time. Each
// tick item stands for one millisecond and yields exactly one result item: the
// pulse width in microseconds and the matching PWM compare count,
// floor(pulse * freq * (2^bits - 1) / 1e6) limited to 2^bits - 1. After more
// than INPUT_TIMEOUT_MS ticks without a throttle command the throttle is forced
// to zero. While the dead time runs, and on the tick that ends it, the output
// is neutral (center pulse in 3D mode, minimum pulse otherwise). Set-throttle,
// set-direction and unused-opcode items are taken without leaving the idle
// state and produce no result. A tick holds the block while it is mapped and
// scaled (percent multiply, reciprocal divide by 100, add, frequency multiply,
// full-scale multiply), divided by one million by a reciprocal multiply, and
// handed to the output register. The output register lets the block take
// further items while a result waits; a tick stalls in its last cycle only
// while an earlier result is still not taken. Configuration is written over
// the APB port, one register per 32-bit word at byte address 4 * index; the
// user must write it only while no tick is in flight, which the block itself
// does not enforce.
module esc_throttle_pulse_controller_core
	import etpc_pkg::*;
#(
	parameter int INPUT_TIMEOUT_MS = 300
) (
	input  logic               clk,
	input  logic               arst_n,
	etpc_stream_if.sink        cmd,
	etpc_stream_if.source      res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t      cfg;
	dp_cmd_t   dp_cmd;
	dp_sts_t   dp_sts;
	cmd_item_t cmd_data;
	res_item_t res_data;
	logic      cmd_ready;
	logic      res_valid;

	assign cmd_data  = cmd.data;
	assign cmd.ready = cmd_ready;
	assign res.valid = res_valid;
	assign res.data  = res_data;

	// Register file: the datapath reads the live register values.
	etpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The controller accepts items only while idle and steps a tick through
	// the datapath stages.
	etpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd_ready),
		.dp_sts   (dp_sts),
		.dp_cmd   (dp_cmd)
	);

	etpc_dp #(
		.INPUT_TIMEOUT_MS (INPUT_TIMEOUT_MS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (cmd_data),
		.cfg       (cfg),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts),
		.out_valid (res_valid),
		.out_ready (res.ready),
		.out_data  (res_data)
	);

endmodule

// ===== rtl/core/etpc_checker.sv =====
// Port-level assertions for the ESC throttle pulse controller.
module etpc_checker
	import etpc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic [1:0] cmd_opcode,
	input logic       res_valid,
	input logic       res_ready
);

	// A waiting result is not withdrawn.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item withdrawn while stalled");

	// A tick keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_opcode == OP_TICK) |=> !cmd_ready)
		else $error("item accepted right after a tick");

	// Other items leave the input ready in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_opcode != OP_TICK) |=> cmd_ready)
		else $error("non-tick item stalled the input");

	// A new result only appears at the end of tick processing.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!cmd_ready))
		else $error("result appeared without tick processing");

endmodule

bind esc_throttle_pulse_controller_core etpc_checker u_etpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_opcode (cmd.data.opcode),
	.res_valid  (res.valid),
	.res_ready  (res.ready)
);

// ===== tb/esc_throttle_pulse_controller_core_test.sv =====
// Self-checking testbench of the ESC throttle pulse controller core.
module esc_throttle_pulse_controller_core_test;
	import etpc_pkg::*;

	// The package names no code for the spare opcode, so it gets one here.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int TIMEOUT_MS   = 300;
	// This margin covers a tick that is still in flight.
	localparam int DRAIN_CYCLES = 32;
	// Longest stretch of cycles without any handshake before the run is declared hung.
	localparam int STALL_LIMIT  = 2000;
	// Length of the deliberate receiver hold-off.
	localparam int HOLD_CYCLES  = 300;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	etpc_stream_if #(.item_t(cmd_item_t)) cmd_if ();
	etpc_stream_if #(.item_t(res_item_t)) res_if ();

	esc_throttle_pulse_controller_core #(
		.INPUT_TIMEOUT_MS(TIMEOUT_MS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Command items waiting to be offered, and pulse results still to arrive.
	cmd_item_t cmd_backlog[$];
	res_item_t pending_pulses[$];

	// Shadow of the register file, as last written over APB.
	cfg_t regs;

	// Predicted controller state.
	logic [6:0]  thr_pct;
	int          idle_ticks;
	logic        dir_back;
	logic        dead_active;
	logic [15:0] dead_left;

	// Idling percentages of the two sides, and the receiver hold-off request.
	int send_gap_pct;
	int recv_gap_pct;
	bit hold_req;
	int hold_left;

	// Set by the monitor when an item was taken at the last rising edge.
	bit cmd_took;

	int stall_cycles;
	int mismatches;
	int items_taken;
	int ticks_taken;
	int results_checked;
	int settings_run;

	initial begin : clock_gen
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Every input of the block is known from time zero; reset is released at a falling edge.
	initial begin : reset_gen
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		res_if.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Maps a throttle percent onto the span from one pulse width to another, truncating
	// the scaled offset toward zero.
	function automatic logic [11:0] map_percent(int pct, int from_us, int to_us);
		int v;
		v = from_us + (pct * (to_us - from_us)) / 100;
		return v[11:0];
	endfunction

	// Converts a pulse width into the PWM compare count at the programmed frequency and
	// resolution. The resolution is clamped to 1..16 bits and the count to full scale.
	function automatic logic [15:0] pulse_to_duty(logic [11:0] us);
		int unsigned nbits;
		longint unsigned top;
		longint unsigned d;
		nbits = regs.pwm_bits;
		if (nbits < 1) nbits = 1;
		if (nbits > 16) nbits = 16;
		top = (64'd1 << nbits) - 64'd1;
		d = (64'(us) * 64'(regs.pwm_freq_hz) * top) / 64'd1000000;
		if (d > top) d = top;
		return d[15:0];
	endfunction

	// Advances the predicted state by one accepted command item. A tick queues the
	// pulse result that the block has to produce for it.
	function automatic void advance_controller(cmd_item_t c);
		logic [11:0] us;
		res_item_t r;
		case (c.opcode)
			OP_SET_THROTTLE: begin
				thr_pct = (c.throttle_percent > PCT_MAX) ? PCT_MAX : c.throttle_percent;
				idle_ticks = 0;
			end
			OP_SET_DIRECTION: begin
				// Only a real change in 3D mode counts; it zeroes the throttle and
				// restarts the dead time.
				if (regs.mode_3d && c.dir_request != dir_back) begin
					dir_back = c.dir_request;
					dead_active = 1'b1;
					dead_left = regs.reverse_dead_ms;
					thr_pct = '0;
				end
			end
			OP_TICK: begin
				// The idle counter saturates one past the timeout, which keeps the
				// failsafe engaged until the next throttle command.
				if (idle_ticks <= TIMEOUT_MS) idle_ticks++;
				if (idle_ticks > TIMEOUT_MS) thr_pct = '0;
				if (dead_active) begin
					// The tick that ends the dead time is still neutral.
					if (dead_left > 0) dead_left--;
					if (dead_left == 0) dead_active = 1'b0;
					us = regs.mode_3d ? regs.pulse_center_us : regs.pulse_min_us;
				end else if (regs.mode_3d) begin
					us = map_percent(thr_pct, regs.pulse_center_us,
						dir_back ? regs.pulse_min_us : regs.pulse_max_us);
				end else begin
					us = map_percent(thr_pct, regs.pulse_min_us, regs.pulse_max_us);
				end
				r.pulse_us = us;
				r.duty_count = pulse_to_duty(us);
				pending_pulses.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// Driver: offers the backlog one item at a time and changes nothing while an
	// offered item waits for ready.
	always @(negedge clk) begin : feeder
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
		end else if (!cmd_if.valid || cmd_took) begin
			if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				cmd_if.data <= cmd_backlog.pop_front();
				cmd_if.valid <= 1'b1;
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
		cmd_took = 1'b0;
	end

	// Receiver: random back-pressure, or a solid hold-off once it is requested.
	always @(negedge clk) begin : sink_ready
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
		end
	end

	// Monitor: predicts on every taken command item, checks every taken result and
	// counts cycles in which neither channel moves.
	always @(posedge clk) begin : monitor
		bit moved;
		res_item_t want;
		moved = 1'b0;
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready) begin
				moved = 1'b1;
				cmd_took = 1'b1;
				items_taken++;
				if (cmd_if.data.opcode == OP_TICK) ticks_taken++;
				advance_controller(cmd_if.data);
			end
			if (res_if.valid && res_if.ready) begin
				moved = 1'b1;
				results_checked++;
				if (pending_pulses.size() == 0) begin
					$display("%0t: result with none pending: duty_count %0d, pulse_us %0d",
						$time, res_if.data.duty_count, res_if.data.pulse_us);
					mismatches++;
				end else begin
					want = pending_pulses.pop_front();
					if (res_if.data.duty_count !== want.duty_count) begin
						$display("%0t: duty_count expected %0d, got %0d",
							$time, want.duty_count, res_if.data.duty_count);
						mismatches++;
					end
					if (res_if.data.pulse_us !== want.pulse_us) begin
						$display("%0t: pulse_us expected %0d, got %0d",
							$time, want.pulse_us, res_if.data.pulse_us);
						mismatches++;
					end
				end
			end
			if (moved) stall_cycles = 0;
			else stall_cycles++;
		end
	end

	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// One APB write: setup cycle, then access cycle until pready; the shadow copy is
	// updated with the bits that the register keeps.
	task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE_3D:      regs.mode_3d = val[0];
			REG_PULSE_MIN:    regs.pulse_min_us = val[11:0];
			REG_PULSE_CENTER: regs.pulse_center_us = val[11:0];
			REG_PULSE_MAX:    regs.pulse_max_us = val[11:0];
			REG_REVERSE_DEAD: regs.reverse_dead_ms = val[15:0];
			REG_PWM_FREQ:     regs.pwm_freq_hz = val[9:0];
			REG_PWM_BITS:     regs.pwm_bits = val[4:0];
			default: ;
		endcase
	endtask

	// Writes all seven registers; called only while the block is idle.
	task automatic load_settings(input cfg_t s);
		reg_write(REG_MODE_3D, PDATA_W'(s.mode_3d));
		reg_write(REG_PULSE_MIN, PDATA_W'(s.pulse_min_us));
		reg_write(REG_PULSE_CENTER, PDATA_W'(s.pulse_center_us));
		reg_write(REG_PULSE_MAX, PDATA_W'(s.pulse_max_us));
		reg_write(REG_REVERSE_DEAD, PDATA_W'(s.reverse_dead_ms));
		reg_write(REG_PWM_FREQ, PDATA_W'(s.pwm_freq_hz));
		reg_write(REG_PWM_BITS, PDATA_W'(s.pwm_bits));
		settings_run++;
	endtask

	// Holds the sender until every offered item is taken and every result has come,
	// then lets a tick that might still be in flight finish.
	task automatic drain_to_idle();
		while (cmd_backlog.size() != 0 || cmd_if.valid || pending_pulses.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic void push_cmd(logic [1:0] op, logic [6:0] pct, logic dir);
		cmd_item_t c;
		c.opcode = op;
		c.throttle_percent = pct;
		c.dir_request = dir;
		cmd_backlog.push_back(c);
	endfunction

	function automatic void push_ticks(int n);
		for (int i = 0; i < n; i++)
			push_cmd(OP_TICK, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
	endfunction

	// Random traffic shaped like a real command stream: a throttle or direction command
	// followed by a short run of ticks, with the spare opcode sprinkled in as noise.
	// Only items that the block acts on count toward n.
	function automatic void add_random(int n);
		int counted;
		int pick;
		int burst;
		counted = 0;
		while (counted < n) begin
			pick = $urandom_range(0, 99);
			burst = $urandom_range(0, 6);
			if (pick < 8) begin
				push_cmd(OP_UNUSED, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
				burst = 0;
			end else if (pick < 40) begin
				// Mostly legal percents; about one in five saturates.
				push_cmd(OP_SET_THROTTLE, ($urandom_range(0, 4) == 0) ?
					7'($urandom_range(101, 127)) : 7'($urandom_range(0, 100)),
					1'($urandom_range(0, 1)));
				counted++;
			end else if (pick < 58) begin
				push_cmd(OP_SET_DIRECTION, 7'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)));
				burst = $urandom_range(0, 8);
				counted++;
			end else begin
				burst = burst + 1;
			end
			push_ticks(burst);
			counted += burst;
		end
	endfunction

	initial begin : stimulus
		cfg_t s;
		send_gap_pct = 0;
		recv_gap_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		cmd_took = 1'b0;
		stall_cycles = 0;
		mismatches = 0;
		items_taken = 0;
		ticks_taken = 0;
		results_checked = 0;
		settings_run = 0;
		thr_pct = '0;
		idle_ticks = 0;
		dir_back = 1'b0;
		dead_active = 1'b0;
		dead_left = '0;
		regs.mode_3d = 1'b0;
		regs.pulse_min_us = 12'd1000;
		regs.pulse_center_us = 12'd1500;
		regs.pulse_max_us = 12'd2000;
		regs.reverse_dead_ms = 16'd0;
		regs.pwm_freq_hz = 10'd50;
		regs.pwm_bits = 5'd16;

		@(posedge arst_n);
		repeat (2) @(negedge clk);

		// Sender idles now and then, receiver most of the time.
		send_gap_pct = 16;
		recv_gap_pct = 72;

		// Standard 3D setup with a two-tick dead time for the directed part.
		s = regs;
		s.mode_3d = 1'b1;
		s.reverse_dead_ms = 16'd2;
		load_settings(s);

		// Percent extremes, saturation above 100, a direction request that changes
		// nothing, real reversals with their neutral ticks, full reverse throttle and
		// the spare opcode.
		push_cmd(OP_SET_THROTTLE, 7'd0, 1'b1);
		push_cmd(OP_TICK, 7'd127, 1'b1);
		push_cmd(OP_SET_THROTTLE, 7'd100, 1'b0);
		push_cmd(OP_TICK, 7'd0, 1'b0);
		push_cmd(OP_SET_THROTTLE, 7'd127, 1'b0);
		push_cmd(OP_TICK, 7'd0, 1'b0);
		push_cmd(OP_SET_THROTTLE, 7'd37, 1'b1);
		push_cmd(OP_TICK, 7'd0, 1'b0);
		push_cmd(OP_SET_DIRECTION, 7'd0, 1'b0);
		push_cmd(OP_TICK, 7'd0, 1'b0);
		push_cmd(OP_SET_DIRECTION, 7'd127, 1'b1);
		push_ticks(4);
		push_cmd(OP_SET_THROTTLE, 7'd100, 1'b0);
		push_cmd(OP_TICK, 7'd0, 1'b0);
		push_cmd(OP_SET_DIRECTION, 7'd0, 1'b1);
		push_cmd(OP_TICK, 7'd0, 1'b0);
		push_cmd(OP_SET_DIRECTION, 7'd0, 1'b0);
		push_ticks(3);
		push_cmd(OP_UNUSED, 7'd127, 1'b1);
		push_cmd(OP_TICK, 7'd0, 1'b0);
		add_random(80);
		drain_to_idle();

		// One-way mode at the power-on pulse widths. The longest dead time is written
		// but cannot start, since direction commands are ignored here.
		s.mode_3d = 1'b0;
		s.pulse_min_us = 12'd1000;
		s.pulse_center_us = 12'd1500;
		s.pulse_max_us = 12'd2000;
		s.reverse_dead_ms = 16'hFFFF;
		s.pwm_freq_hz = 10'd50;
		s.pwm_bits = 5'd16;
		load_settings(s);
		add_random(90);
		drain_to_idle();

		// From here the sender idles most of the time and the receiver rarely.
		send_gap_pct = 72;
		recv_gap_pct = 16;

		// 3D mode with inverted extremes, no dead time (one neutral tick per reversal)
		// and the highest legal frequency, so the duty count saturates.
		s.mode_3d = 1'b1;
		s.pulse_min_us = 12'd2500;
		s.pulse_center_us = 12'd0;
		s.pulse_max_us = 12'd0;
		s.reverse_dead_ms = 16'd0;
		s.pwm_freq_hz = 10'd1000;
		s.pwm_bits = 5'd16;
		load_settings(s);
		add_random(90);
		drain_to_idle();

		// One-way, widest span, lowest frequency and a one-bit duty. A full-throttle
		// command followed by a long silence runs the command-loss failsafe.
		s.mode_3d = 1'b0;
		s.pulse_min_us = 12'd0;
		s.pulse_center_us = 12'd2500;
		s.pulse_max_us = 12'd2500;
		s.reverse_dead_ms = 16'd1;
		s.pwm_freq_hz = 10'd1;
		s.pwm_bits = 5'd1;
		load_settings(s);
		push_cmd(OP_SET_THROTTLE, 7'd100, 1'b0);
		push_ticks(TIMEOUT_MS + 5);
		push_cmd(OP_SET_THROTTLE, 7'd60, 1'b1);
		push_ticks(3);
		add_random(20);
		drain_to_idle();

		// Neither side idles from here on.
		send_gap_pct = 0;
		recv_gap_pct = 0;

		// Out-of-range widths and frequency, a resolution of zero that clamps to one
		// bit. The receiver holds off for a long stretch first so that a finished
		// result blocks the next tick and the block stops taking items.
		s.mode_3d = 1'b1;
		s.pulse_min_us = 12'd0;
		s.pulse_center_us = 12'd2500;
		s.pulse_max_us = 12'hFFF;
		s.reverse_dead_ms = 16'd5;
		s.pwm_freq_hz = 10'h3FF;
		s.pwm_bits = 5'd0;
		load_settings(s);
		@(posedge clk);
		hold_req = 1'b1;
		push_cmd(OP_SET_THROTTLE, 7'd80, 1'b0);
		push_ticks(8);
		add_random(85);
		drain_to_idle();

		// Zero frequency gives a zero count whatever the pulse; a resolution above
		// sixteen bits clamps to sixteen.
		s.mode_3d = 1'($urandom_range(0, 1));
		s.pulse_min_us = 12'($urandom_range(0, 4095));
		s.pulse_center_us = 12'($urandom_range(0, 4095));
		s.pulse_max_us = 12'($urandom_range(0, 4095));
		s.reverse_dead_ms = 16'($urandom_range(0, 10));
		s.pwm_freq_hz = 10'd0;
		s.pwm_bits = 5'($urandom_range(17, 31));
		load_settings(s);
		add_random(85);
		drain_to_idle();

		// A random setting inside the legal ranges.
		s.mode_3d = 1'($urandom_range(0, 1));
		s.pulse_min_us = 12'($urandom_range(0, 2500));
		s.pulse_center_us = 12'($urandom_range(0, 2500));
		s.pulse_max_us = 12'($urandom_range(0, 2500));
		s.reverse_dead_ms = 16'($urandom_range(0, 12));
		s.pwm_freq_hz = 10'($urandom_range(1, 1000));
		s.pwm_bits = 5'($urandom_range(1, 16));
		load_settings(s);
		add_random(85);
		drain_to_idle();

		$display("Covered %0d command items, %0d of them ticks, over %0d register settings.",
			items_taken, ticks_taken, settings_run);
		$display("Checked %0d pulse results, with a failsafe timeout and a receiver hold-off.",
			results_checked);
		if (mismatches == 0 && pending_pulses.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
